### design/rmq_pkg.sv
// Package for the rotation matrix to quaternion block.
// Shared types and codes; no dependencies.
package rmq_pkg;

  // Which quaternion component came out largest.
  typedef enum logic [1:0] {
    COMP_W = 2'd0,
    COMP_X = 2'd1,
    COMP_Y = 2'd2,
    COMP_Z = 2'd3
  } comp_t;

endpackage

### design/rmq_if.sv
// Channel interfaces for the rotation matrix to quaternion block.
// Depends on rmq_pkg.
interface rmq_in_if #(parameter int FRAC_BITS = 16);
  logic                       valid;
  logic                       ready;
  logic signed [FRAC_BITS+1:0] m_0_0, m_0_1, m_0_2;
  logic signed [FRAC_BITS+1:0] m_1_0, m_1_1, m_1_2;
  logic signed [FRAC_BITS+1:0] m_2_0, m_2_1, m_2_2;

  modport source (output valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
                  m_2_0, m_2_1, m_2_2, input ready);
  modport sink (input valid, m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2,
                m_2_0, m_2_1, m_2_2, output ready);
endinterface

interface rmq_out_if #(parameter int FRAC_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] quat_x, quat_y, quat_z, quat_w;
  rmq_pkg::comp_t              largest_component;
  logic                        degenerate;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, largest_component,
                  degenerate, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, largest_component,
                degenerate, output ready);
endinterface

### design/rmq_div_lane.sv
// Pipelined restoring divider lane: round(mag * 2^F / (4 * big)), signed, saturated.
// One quotient bit per stage; stage enables come from the top level. No package use.
module rmq_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [FRAC_BITS+3:0]        en,
  input  logic [FRAC_BITS+2:0]        mag_i,
  input  logic                        neg_i,
  input  logic [FRAC_BITS:0]          big_i,
  output logic signed [FRAC_BITS+1:0] q_o
);
  localparam int F    = FRAC_BITS;
  localparam int DB   = F + 2;
  localparam int NW   = 2 * F + 3;
  localparam int DNW  = F + 3;
  localparam int CMPW = 2 * F + 5;
  localparam logic [DB-1:0]        QHALF = DB'(1) << (DB - 1);
  localparam logic signed [DB-1:0] QMAX  = signed'(QHALF - DB'(1));
  localparam logic signed [DB-1:0] QMIN  = signed'(QHALF);

  logic [NW-1:0]  rem_r [DB+1];
  logic [DNW-1:0] den_r [DB+1];
  logic           neg_r [DB+1];
  logic           ovf_r [DB+1];
  logic [DB-1:0]  q_r   [DB+1];

  // numerator with the rounding half-divisor folded in
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= (NW'(mag_i) << F) + NW'({big_i, 1'b0});
      den_r[0] <= {big_i, 2'b00};
      neg_r[0] <= neg_i;
      ovf_r[0] <= 1'b0;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= DB; j++) begin : g_bit
    logic [CMPW-1:0] dsh;
    logic            ge;
    logic            ovf_nxt;
    assign dsh = CMPW'(den_r[j-1]) << (DB - j);
    assign ge  = CMPW'(rem_r[j-1]) >= dsh;
    if (j == 1) begin : g_first
      assign ovf_nxt = CMPW'(rem_r[0]) >= (CMPW'(den_r[0]) << DB);
    end else begin : g_rest
      assign ovf_nxt = ovf_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= ge ? NW'(CMPW'(rem_r[j-1]) - dsh) : rem_r[j-1];
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_nxt;
        q_r[j]   <= {q_r[j-1][DB-2:0], ge};
      end
    end
  end

  logic              pos_sat, neg_sat;
  logic signed [DB-1:0] q_nxt;
  always_comb begin
    pos_sat = ovf_r[DB] || q_r[DB][DB-1];
    neg_sat = ovf_r[DB] || (q_r[DB] > QHALF);
    if (neg_r[DB]) begin
      q_nxt = neg_sat ? QMIN : -signed'(q_r[DB]);
    end else begin
      q_nxt = pos_sat ? QMAX : signed'(q_r[DB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[DB+1]) begin
      q_o <= q_nxt;
    end
  end
endmodule

### design/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion (largest-component method), fully pipelined.
// Depends on rmq_pkg, rmq_in_if, rmq_out_if and rmq_div_lane.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------
//  in_ch    | in  | m_c_r, nine signed Q(FRAC_BITS) entries   | valid/ready
//  out_ch   | out | quat_x/y/z/w, largest_component, degenerate| valid/ready
//
// One transaction per cycle sustained while out_ch.ready stays high. The pipe
// has two stages for candidates and selection, FRAC_BITS+2 square-root stages
// (one root bit each), FRAC_BITS+4 divider stages (one quotient bit each, plus
// numerator setup and saturation) and the output register.
// Reset (synchronous, active low) clears only the stage valid bits.
// Each stage holds when it is full and the one after it cannot take its
// contents, so bubbles collapse and a stall neither drops nor repeats data.
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int DB     = F + 2;        // data width
  localparam int CW     = DB + 2;       // candidate width
  localparam int RW     = DB + 3;       // radicand width
  localparam int DW     = DB + 1;       // off-diagonal sum width / magnitude
  localparam int SQ     = F + 2;        // root bits
  localparam int XW     = 2 * SQ;
  localparam int RMW    = SQ + 3;
  localparam int SQ_S0  = 2;
  localparam int LN_S0  = SQ_S0 + SQ;
  localparam int OUT_S  = LN_S0 + DB + 2;
  localparam int NSTG   = OUT_S + 1;
  localparam logic signed [RW-1:0] RAD_ONE = RW'(1) << F;
  localparam logic signed [DB-1:0] Q_ONE   = DB'(1) << F;

  // ---------------- stage control ----------------
  logic [NSTG-1:0] v_r, v_nxt, v_shift;
  logic [NSTG:0]   en;

  assign en[NSTG] = out_ch.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign v_shift = {v_r[NSTG-2:0], in_ch.valid};
  assign v_nxt   = (v_shift & en[NSTG-1:0]) | (v_r & ~en[NSTG-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[OUT_S];

  // ---------------- stage 0: candidates and off-diagonal terms ----------------
  logic signed [CW-1:0] c_r [4];
  logic signed [DW-1:0] s12m_r, s20m_r, s01m_r, s12p_r, s20p_r, s01p_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_r[0] <= CW'(in_ch.m_0_0) + CW'(in_ch.m_1_1) + CW'(in_ch.m_2_2);
      c_r[1] <= CW'(in_ch.m_0_0) - CW'(in_ch.m_1_1) - CW'(in_ch.m_2_2);
      c_r[2] <= CW'(in_ch.m_1_1) - CW'(in_ch.m_0_0) - CW'(in_ch.m_2_2);
      c_r[3] <= CW'(in_ch.m_2_2) - CW'(in_ch.m_0_0) - CW'(in_ch.m_1_1);
      s12m_r <= DW'(in_ch.m_1_2) - DW'(in_ch.m_2_1);
      s20m_r <= DW'(in_ch.m_2_0) - DW'(in_ch.m_0_2);
      s01m_r <= DW'(in_ch.m_0_1) - DW'(in_ch.m_1_0);
      s12p_r <= DW'(in_ch.m_1_2) + DW'(in_ch.m_2_1);
      s20p_r <= DW'(in_ch.m_2_0) + DW'(in_ch.m_0_2);
      s01p_r <= DW'(in_ch.m_0_1) + DW'(in_ch.m_1_0);
    end
  end

  // ---------------- stage 1: pick largest, radicand, lane operands ----------------
  logic signed [CW-1:0] best;
  comp_t                idx_nxt;
  logic signed [RW-1:0] rad;
  logic signed [DW-1:0] ld [3];

  always_comb begin
    best    = c_r[0];
    idx_nxt = COMP_W;
    if (c_r[1] > best) begin
      best    = c_r[1];
      idx_nxt = COMP_X;
    end
    if (c_r[2] > best) begin
      best    = c_r[2];
      idx_nxt = COMP_Y;
    end
    if (c_r[3] > best) begin
      best    = c_r[3];
      idx_nxt = COMP_Z;
    end
    rad = RW'(best) + RAD_ONE;
    // the three components other than the largest, in x, y, z, w order
    case (idx_nxt)
      COMP_W: begin
        ld[0] = s12m_r; ld[1] = s20m_r; ld[2] = s01m_r;
      end
      COMP_X: begin
        ld[0] = s01p_r; ld[1] = s20p_r; ld[2] = s12m_r;
      end
      COMP_Y: begin
        ld[0] = s01p_r; ld[1] = s12p_r; ld[2] = s20m_r;
      end
      default: begin
        ld[0] = s20p_r; ld[1] = s12p_r; ld[2] = s01m_r;
      end
    endcase
  end

  logic [XW-1:0] x1_r;
  comp_t         idx1_r;
  logic          dgn1_r;
  logic [DW-1:0] mag1_r [3];
  logic          neg1_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1_r   <= {1'b0, rad[F+2:0], {F{1'b0}}};
      idx1_r <= idx_nxt;
      dgn1_r <= rad[RW-1] || (rad == '0);
      for (int l = 0; l < 3; l++) begin
        neg1_r[l] <= ld[l][DW-1];
        mag1_r[l] <= ld[l][DW-1] ? DW'(-ld[l]) : DW'(ld[l]);
      end
    end
  end

  // ---------------- square root: one root bit per stage ----------------
  logic [XW-1:0]  sx_r    [SQ];
  logic [RMW-1:0] srem_r  [SQ];
  logic [SQ-1:0]  sroot_r [SQ];
  comp_t          sidx_r  [SQ];
  logic           sdgn_r  [SQ];
  logic [DW-1:0]  smag_r  [SQ][3];
  logic           sneg_r  [SQ][3];

  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    logic [XW-1:0]  x_in;
    logic [RMW-1:0] rem_in, acc, trial;
    logic [SQ-1:0]  root_in;
    comp_t          idx_in;
    logic           dgn_in, ge;
    logic [DW-1:0]  mag_in [3];
    logic           neg_in [3];

    if (s == 0) begin : g_head
      assign x_in    = x1_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign idx_in  = idx1_r;
      assign dgn_in  = dgn1_r;
      assign mag_in  = mag1_r;
      assign neg_in  = neg1_r;
    end else begin : g_body
      assign x_in    = sx_r[s-1];
      assign rem_in  = srem_r[s-1];
      assign root_in = sroot_r[s-1];
      assign idx_in  = sidx_r[s-1];
      assign dgn_in  = sdgn_r[s-1];
      assign mag_in  = smag_r[s-1];
      assign neg_in  = sneg_r[s-1];
    end

    assign acc   = {rem_in[RMW-3:0], x_in[XW-1:XW-2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (en[SQ_S0+s]) begin
        sx_r[s]    <= x_in << 2;
        srem_r[s]  <= ge ? acc - trial : acc;
        sroot_r[s] <= {root_in[SQ-2:0], ge};
        sidx_r[s]  <= idx_in;
        sdgn_r[s]  <= dgn_in;
        smag_r[s]  <= mag_in;
        sneg_r[s]  <= neg_in;
      end
    end
  end

  // ---------------- divider lanes ----------------
  logic [F:0]           big;
  logic signed [DB-1:0] lq [3];

  assign big = sroot_r[SQ-1][SQ-1:1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en[LN_S0 +: DB+2]),
      .mag_i (smag_r[SQ-1][l]),
      .neg_i (sneg_r[SQ-1][l]),
      .big_i (big),
      .q_o   (lq[l])
    );
  end

  // sideband alongside the lanes
  comp_t      lidx_r [DB+2];
  logic       ldgn_r [DB+2];
  logic [F:0] lbig_r [DB+2];

  for (genvar j = 0; j < DB + 2; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[LN_S0+j]) begin
        if (j == 0) begin
          lidx_r[j] <= sidx_r[SQ-1];
          ldgn_r[j] <= sdgn_r[SQ-1];
          lbig_r[j] <= big;
        end else begin
          lidx_r[j] <= lidx_r[j-1];
          ldgn_r[j] <= ldgn_r[j-1];
          lbig_r[j] <= lbig_r[j-1];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [DB-1:0] bq;
  logic signed [DB-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;

  // largest component stays below 1.33 in this format, no saturation needed
  assign bq = signed'(DB'(lbig_r[DB+1]));

  always_comb begin
    case (lidx_r[DB+1])
      COMP_W: begin
        qx_nxt = lq[0]; qy_nxt = lq[1]; qz_nxt = lq[2]; qw_nxt = bq;
      end
      COMP_X: begin
        qx_nxt = bq; qy_nxt = lq[0]; qz_nxt = lq[1]; qw_nxt = lq[2];
      end
      COMP_Y: begin
        qx_nxt = lq[0]; qy_nxt = bq; qz_nxt = lq[1]; qw_nxt = lq[2];
      end
      default: begin
        qx_nxt = lq[0]; qy_nxt = lq[1]; qz_nxt = bq; qw_nxt = lq[2];
      end
    endcase
    if (ldgn_r[DB+1]) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_S]) begin
      out_ch.quat_x            <= qx_nxt;
      out_ch.quat_y            <= qy_nxt;
      out_ch.quat_z            <= qz_nxt;
      out_ch.quat_w            <= qw_nxt;
      out_ch.largest_component <= lidx_r[DB+1];
      out_ch.degenerate        <= ldgn_r[DB+1];
    end
  end

  // ---------------- assertions ----------------
  // an empty output register frees the whole pipe
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[OUT_S] |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  // degenerate transactions carry the identity quaternion
  a_degenerate_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.quat_w == Q_ONE && out_ch.quat_x == '0 &&
      out_ch.quat_y == '0 && out_ch.quat_z == '0)
    else $error("degenerate result is not the identity");

  // the named largest component is strictly positive
  a_largest_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.degenerate |->
      (out_ch.largest_component == COMP_W && out_ch.quat_w > 0) ||
      (out_ch.largest_component == COMP_X && out_ch.quat_x > 0) ||
      (out_ch.largest_component == COMP_Y && out_ch.quat_y > 0) ||
      (out_ch.largest_component == COMP_Z && out_ch.quat_z > 0))
    else $error("largest component not positive");
endmodule
